@@ src/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   typedef enum logic [1:0] {
      OP_PUT    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_READ   = 2'd3
   } tcw_op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_COPY,
      ST_DRAIN,
      ST_BLANK,
      ST_DONE
   } tcw_state_type;

   typedef enum logic [1:0] {
      PTR_ZERO,
      PTR_SECOND_ROW,
      PTR_LAST_ROW
   } tcw_ptr_sel_type;

   typedef struct packed {
      logic            accept;
      logic            copy;
      logic            blank;
      logic            init_attr;
      logic            ptr_load;
      tcw_ptr_sel_type ptr_sel;
      logic            load_rsp;
   } tcw_cmd_type;

   typedef struct packed {
      logic clear_req;
      logic scroll_req;
      logic ptr_last;
      logic rsp_free;
   } tcw_status_type;

   localparam logic [7:0] CH_NEWLINE       = 8'h0A;
   localparam logic [7:0] CH_TAB           = 8'h09;
   localparam logic [7:0] CH_SPACE         = 8'h20;
   localparam logic [7:0] BLANK_ATTR_RESET = 8'h07;

endpackage

@@ src/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: reset clearing pass, item accept, scroll copy, blank sweeps and
// result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  tcw_status_type status,
   output tcw_cmd_type    cmd
);

   tcw_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.ptr_sel   = PTR_ZERO;
      req_ready     = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.blank     = 1'b1;
            cmd.init_attr = 1'b1;
            if (status.ptr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.clear_req) begin
                  cmd.ptr_load = 1'b1;
                  cmd.ptr_sel  = PTR_ZERO;
                  state_in     = ST_BLANK;
               end else if (status.scroll_req) begin
                  cmd.ptr_load = 1'b1;
                  cmd.ptr_sel  = PTR_SECOND_ROW;
                  state_in     = ST_COPY;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_COPY: begin
            cmd.copy = 1'b1;
            if (status.ptr_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last copied row word lands here; then blank the bottom row
            cmd.ptr_load = 1'b1;
            cmd.ptr_sel  = PTR_LAST_ROW;
            state_in     = ST_BLANK;
         end
         ST_BLANK: begin
            cmd.blank = 1'b1;
            if (status.ptr_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

endmodule

@@ src/tcw_datapath.sv @@
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen memory (character and attribute byte lanes), cursor, sweep pointer,
// blank attribute register and result register.
// ----------------------------------------------------------------------------
module tcw_datapath
   import tcw_pkg::*;
#(
   parameter int COLUMNS     = 80,
   parameter int ROWS        = 25,
   parameter int TAB_ADVANCE = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_wr_en,
   input  logic [7:0]     csr_wr_data,
   input  logic [1:0]     req_opcode,
   input  logic [7:0]     req_char_code,
   input  logic [10:0]    req_cell_index,
   input  tcw_cmd_type    cmd,
   output tcw_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [10:0]    rsp_cursor_position,
   output logic [15:0]    rsp_cell_data
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);

   logic [7:0] char_mem [0:CELLS-1];
   logic [7:0] attr_mem [0:CELLS-1];

   logic [7:0]    blank_attr_ff;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] ptr_ff;
   logic          cp_valid_ff;
   logic [AW-1:0] cp_addr_ff;
   logic [7:0]    rd_char_ff, rd_attr_ff;
   logic          data_sel_ff;
   logic          rsp_valid_ff;
   logic [10:0]   rsp_pos_ff;
   logic [15:0]   rsp_data_ff;

   tcw_op_type    op;
   logic [AW-1:0] cur_pos;
   logic [CW:0]   step;
   logic [CW:0]   col_sum;
   logic          bottom;
   logic          origin;
   logic          in_range;
   logic          scroll_req;
   logic          item_we, item_attr_we;
   logic [AW-1:0] item_waddr;

   logic          we, attr_we, re;
   logic [AW-1:0] waddr, raddr;
   logic [7:0]    wchar, wattr;

   assign op       = tcw_op_type'(req_opcode);
   assign cur_pos  = AW'(row_ff) * AW'(COLUMNS) + AW'(col_ff);
   assign step     = (req_char_code == CH_TAB) ? (CW+1)'(TAB_ADVANCE) : (CW+1)'(1);
   assign col_sum  = {1'b0, col_ff} + step;
   assign bottom   = (row_ff == RW'(ROWS - 1));
   assign origin   = (col_ff == '0) && (row_ff == '0);
   assign in_range = 32'(req_cell_index) < 32'(CELLS);

   // cursor move and single-cell write of the item at the input
   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      scroll_req   = 1'b0;
      item_we      = 1'b0;
      item_attr_we = 1'b0;
      item_waddr   = cur_pos;
      case (op)
         OP_PUT: begin
            if (req_char_code == CH_NEWLINE) begin
               col_in = '0;
               if (bottom) begin
                  scroll_req = 1'b1;
               end else begin
                  row_in = row_ff + RW'(1);
               end
            end else begin
               item_we = (req_char_code != CH_TAB);
               if (col_sum >= (CW+1)'(COLUMNS)) begin
                  col_in = CW'(col_sum - (CW+1)'(COLUMNS));
                  if (bottom) begin
                     scroll_req = 1'b1;
                  end else begin
                     row_in = row_ff + RW'(1);
                  end
               end else begin
                  col_in = CW'(col_sum);
               end
            end
         end
         OP_REMOVE: begin
            if (!origin) begin
               if (col_ff == '0) begin
                  row_in = row_ff - RW'(1);
                  col_in = CW'(COLUMNS - 1);
               end else begin
                  col_in = col_ff - CW'(1);
               end
               // one cell back in linear order, row wrap included
               item_we      = 1'b1;
               item_attr_we = 1'b1;
               item_waddr   = cur_pos - AW'(1);
            end
         end
         default: ;
      endcase
   end

   // memory port selection
   always_comb begin
      we      = 1'b0;
      attr_we = 1'b0;
      waddr   = ptr_ff;
      wchar   = CH_SPACE;
      wattr   = blank_attr_ff;
      re      = 1'b0;
      raddr   = ptr_ff;
      if (cmd.accept) begin
         we      = item_we;
         attr_we = item_attr_we;
         waddr   = item_waddr;
         if (op == OP_PUT) begin
            wchar = req_char_code;
         end
         if (op == OP_READ) begin
            re    = in_range;
            raddr = AW'(req_cell_index);
         end
      end else if (cmd.blank) begin
         we      = 1'b1;
         attr_we = 1'b1;
         wattr   = cmd.init_attr ? BLANK_ATTR_RESET : blank_attr_ff;
      end else if (cp_valid_ff) begin
         we      = 1'b1;
         attr_we = 1'b1;
         waddr   = cp_addr_ff;
         wchar   = rd_char_ff;
         wattr   = rd_attr_ff;
      end
      if (cmd.copy) begin
         re = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         char_mem[waddr] <= wchar;
         if (attr_we) begin
            attr_mem[waddr] <= wattr;
         end
      end
      if (re) begin
         rd_char_ff <= char_mem[raddr];
         rd_attr_ff <= attr_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blank_attr_ff <= BLANK_ATTR_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         ptr_ff        <= '0;
         cp_valid_ff   <= 1'b0;
         data_sel_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            blank_attr_ff <= csr_wr_data;
         end
         if (cmd.accept) begin
            col_ff      <= col_in;
            row_ff      <= row_in;
            data_sel_ff <= (op == OP_READ) && in_range;
         end
         if (cmd.ptr_load) begin
            case (cmd.ptr_sel)
               PTR_ZERO:       ptr_ff <= '0;
               PTR_SECOND_ROW: ptr_ff <= AW'(COLUMNS);
               PTR_LAST_ROW:   ptr_ff <= AW'(CELLS - COLUMNS);
               default:        ptr_ff <= '0;
            endcase
         end else if (cmd.blank || cmd.copy) begin
            ptr_ff <= ptr_ff + AW'(1);
         end
         cp_valid_ff <= cmd.copy;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // copy destination trails the source by one row
   always_ff @(posedge clock) begin
      cp_addr_ff <= ptr_ff - AW'(COLUMNS);
      if (cmd.load_rsp) begin
         rsp_pos_ff  <= 11'(cur_pos);
         rsp_data_ff <= data_sel_ff ? {rd_attr_ff, rd_char_ff} : 16'h0000;
      end
   end

   assign status.clear_req  = (op == OP_CLEAR);
   assign status.scroll_req = scroll_req;
   assign status.ptr_last   = (ptr_ff == AW'(CELLS - 1));
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cell_data       = rsp_data_ff;

endmodule

@@ src/text_console_writer_core.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_core
// Character-cell text console: screen store, cursor, scroll and clear.
// ----------------------------------------------------------------------------
// One request is worked at a time; the next is taken once the previous one
// has its result loaded into the output register, which may still be waiting
// for rsp_ready. A put that scrolls copies the screen up one row (one copy
// word per cycle through the single-write, single-read screen memory, a
// drain state for the last copied word, then the bottom row blanked).
// A clear blanks all ROWS*COLUMNS cells. After reset a clearing pass over
// all ROWS*COLUMNS cells runs before the first request is taken; csr writes
// are taken throughout.
module text_console_writer_core
   import tcw_pkg::*;
#(
   parameter int COLUMNS     = 80,
   parameter int ROWS        = 25,
   parameter int TAB_ADVANCE = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_cell_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [10:0] rsp_cursor_position,
   output logic [15:0] rsp_cell_data
);

   tcw_cmd_type    cmd;
   tcw_status_type status;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .COLUMNS     (COLUMNS),
      .ROWS        (ROWS),
      .TAB_ADVANCE (TAB_ADVANCE)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_opcode          (req_opcode),
      .req_char_code       (req_char_code),
      .req_cell_index      (req_cell_index),
      .cmd                 (cmd),
      .status              (status),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cell_data       (rsp_cell_data)
   );

endmodule
